/* rtl/core/aliq_pkg.sv */
// Shared types, constants and the control program of the aliquot sum unit.
package aliq_pkg;

  localparam int NUM_BITS_DEFAULT = 20;
  localparam int LIMIT_W = 20;
  localparam int COUNT_W = 8;
  localparam int SUM_W = 23;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd10000;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Datapath action selected by one control word.
  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_INIT,
    ACT_DIV_GO,
    ACT_ACCUM,
    ACT_SAVE1,
    ACT_FIN_ZERO,
    ACT_FIN_ONE,
    ACT_FIN_TWO
  } act_t;

  // Jump condition of one control word.
  typedef enum logic [2:0] {
    BR_NONE,
    BR_ALWAYS,
    BR_NO_START,
    BR_LT2,
    BR_SQ_GT_M,
    BR_DIV_BUSY,
    BR_NOT_CAND
  } br_t;

  typedef struct packed {
    act_t  act;
    br_t   br;
    step_t tgt;
  } uword_t;

  // Status flags from the datapath that the jumps test.
  typedef struct packed {
    logic lt2;
    logic sq_gt_m;
    logic div_busy;
    logic cand;
  } stat_t;

  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_CHK  = 4'd1;
  localparam step_t STEP_L1   = 4'd2;
  localparam step_t STEP_D1   = 4'd3;
  localparam step_t STEP_W1   = 4'd4;
  localparam step_t STEP_A1   = 4'd5;
  localparam step_t STEP_E1   = 4'd6;
  localparam step_t STEP_L2   = 4'd7;
  localparam step_t STEP_D2   = 4'd8;
  localparam step_t STEP_W2   = 4'd9;
  localparam step_t STEP_A2   = 4'd10;
  localparam step_t STEP_F2   = 4'd11;
  localparam step_t STEP_F1   = 4'd12;
  localparam step_t STEP_F0   = 4'd13;

  // Control program. The first loop sums the divisors of the number, the second
  // loop sums the divisors of that sum when it may be an amicable partner.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{act: ACT_NOP, br: BR_ALWAYS, tgt: STEP_IDLE};
    unique case (s)
      STEP_IDLE: w = '{act: ACT_INIT,     br: BR_NO_START, tgt: STEP_IDLE};
      STEP_CHK:  w = '{act: ACT_NOP,      br: BR_LT2,      tgt: STEP_F0};
      STEP_L1:   w = '{act: ACT_NOP,      br: BR_SQ_GT_M,  tgt: STEP_E1};
      STEP_D1:   w = '{act: ACT_DIV_GO,   br: BR_NONE,     tgt: STEP_IDLE};
      STEP_W1:   w = '{act: ACT_NOP,      br: BR_DIV_BUSY, tgt: STEP_W1};
      STEP_A1:   w = '{act: ACT_ACCUM,    br: BR_ALWAYS,   tgt: STEP_L1};
      STEP_E1:   w = '{act: ACT_SAVE1,    br: BR_NOT_CAND, tgt: STEP_F1};
      STEP_L2:   w = '{act: ACT_NOP,      br: BR_SQ_GT_M,  tgt: STEP_F2};
      STEP_D2:   w = '{act: ACT_DIV_GO,   br: BR_NONE,     tgt: STEP_IDLE};
      STEP_W2:   w = '{act: ACT_NOP,      br: BR_DIV_BUSY, tgt: STEP_W2};
      STEP_A2:   w = '{act: ACT_ACCUM,    br: BR_ALWAYS,   tgt: STEP_L2};
      STEP_F2:   w = '{act: ACT_FIN_TWO,  br: BR_ALWAYS,   tgt: STEP_IDLE};
      STEP_F1:   w = '{act: ACT_FIN_ONE,  br: BR_ALWAYS,   tgt: STEP_IDLE};
      STEP_F0:   w = '{act: ACT_FIN_ZERO, br: BR_ALWAYS,   tgt: STEP_IDLE};
      default:   w = '{act: ACT_NOP,      br: BR_ALWAYS,   tgt: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/aliquot_sum_perfect_amicable_unit.sv */
// Top level of the aliquot sum, perfect and amicable test unit.
// A transaction starts when start is high while busy is low; number is taken at that
// edge. The unit sums proper divisors by trial division, one divisor candidate i per
// loop pass while i*i <= operand, using a shared one-bit-per-cycle divider of
// W = max(NUM_BITS, 20) bits. Each candidate passes the loop check, divider start,
// divider wait and accumulate steps. The partner pass over the divisors of s, the
// aliquot sum of n, runs only when n < s <= partner_limit; numbers below two go
// straight to an all-zero result. The result appears on the output ports for one
// cycle with done high; busy is already low in that cycle, so the next transaction
// can be accepted at its closing edge. The receiver cannot stall the result, so it
// must capture it then. partner_limit is written through cfg_we and cfg_wdata; the
// user must write it only while busy is low, as the block itself leaves this check
// to the user.
module aliquot_sum_perfect_amicable_unit #(
  parameter int NUM_BITS = aliq_pkg::NUM_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [NUM_BITS-1:0]          number,
  input  logic                         cfg_we,
  input  logic [aliq_pkg::LIMIT_W-1:0] cfg_wdata,
  output logic                         done,
  output logic [aliq_pkg::COUNT_W-1:0] divisor_count,
  output logic [aliq_pkg::SUM_W-1:0]   divisor_sum,
  output logic                         is_perfect,
  output logic                         is_amicable_low,
  output logic [aliq_pkg::LIMIT_W-1:0] partner
);

  aliq_pkg::act_t  act;
  aliq_pkg::stat_t stat;

  aliq_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .act  (act),
    .busy (busy)
  );

  aliq_dp #(
    .NUM_BITS(NUM_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .act            (act),
    .number         (number),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .stat           (stat),
    .done           (done),
    .divisor_count  (divisor_count),
    .divisor_sum    (divisor_sum),
    .is_perfect     (is_perfect),
    .is_amicable_low(is_amicable_low),
    .partner        (partner)
  );

  // A perfect number never goes through the partner test.
  a_perfect_not_amicable: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_perfect && is_amicable_low))
    else $error("perfect and amicable flags both set");

  a_partner_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !is_amicable_low) |-> (partner == '0))
    else $error("partner nonzero without amicable flag");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // The result is delivered on the last step, so the unit is free right after it.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high while result is shown");

endmodule

/* rtl/core/aliq_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module aliq_div #(
  parameter int OPW = 20,
  parameter int IW = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic [OPW-1:0] dividend,
  input  logic [IW-1:0]  divisor,
  output logic           busy,
  output logic [OPW-1:0] quotient,
  output logic [IW-1:0]  remainder
);

  localparam int CW = $clog2(OPW);

  logic [CW-1:0] cnt;
  logic [IW:0]   trial;
  logic [IW:0]   diff;
  logic          fits;

  // The quotient register starts out holding the dividend and shifts it out
  // from the top while quotient bits enter from the bottom.
  assign trial = {remainder, quotient[OPW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
    end else if (busy && (cnt == CW'(OPW - 1))) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cnt       <= '0;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      cnt       <= cnt + CW'(1);
      quotient  <= {quotient[OPW-2:0], fits};
      remainder <= fits ? diff[IW-1:0] : trial[IW-1:0];
    end
  end

endmodule

/* rtl/core/aliq_dp.sv */
// Datapath: operand, trial divisor, running sums, limit register and result registers.
module aliq_dp #(
  parameter int NUM_BITS = aliq_pkg::NUM_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  aliq_pkg::act_t               act,
  input  logic [NUM_BITS-1:0]          number,
  input  logic                         cfg_we,
  input  logic [aliq_pkg::LIMIT_W-1:0] cfg_wdata,
  output aliq_pkg::stat_t              stat,
  output logic                         done,
  output logic [aliq_pkg::COUNT_W-1:0] divisor_count,
  output logic [aliq_pkg::SUM_W-1:0]   divisor_sum,
  output logic                         is_perfect,
  output logic                         is_amicable_low,
  output logic [aliq_pkg::LIMIT_W-1:0] partner
);

  // The operand is either the number or a partner candidate no larger than the limit.
  localparam int OPW  = (NUM_BITS > aliq_pkg::LIMIT_W) ? NUM_BITS : aliq_pkg::LIMIT_W;
  localparam int IW   = (OPW + 1) / 2 + 1;
  localparam int SQW  = 2 * IW;
  localparam int ACCW = OPW + 3;

  logic [OPW-1:0]               n;
  logic [OPW-1:0]               m;
  logic [IW-1:0]                i;
  logic [SQW-1:0]               sq;
  logic [ACCW-1:0]              acc;
  logic [aliq_pkg::COUNT_W-1:0] cnt;
  logic [ACCW-1:0]              s1;
  logic [aliq_pkg::COUNT_W-1:0] c1;
  logic [aliq_pkg::LIMIT_W-1:0] limit;

  logic [OPW-1:0]               quo;
  logic [IW-1:0]                rem;
  logic                         div_busy;
  logic                         divides;
  logic                         single;
  logic [ACCW-1:0]              add_val;
  logic [aliq_pkg::COUNT_W-1:0] cnt_inc;
  logic                         back_to_n;

  aliq_div #(
    .OPW(OPW),
    .IW (IW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (act == aliq_pkg::ACT_DIV_GO),
    .dividend (m),
    .divisor  (i),
    .busy     (div_busy),
    .quotient (quo),
    .remainder(rem)
  );

  assign stat.lt2      = n < OPW'(2);
  assign stat.sq_gt_m  = sq > SQW'(m);
  assign stat.div_busy = div_busy;
  assign stat.cand     = (ACCW'(n) < acc) && (acc <= ACCW'(limit));

  // Divisor 1 and an exact square root count once; other divisors bring their cofactor.
  assign divides   = rem == '0;
  assign single    = (i == IW'(1)) || (sq == SQW'(m));
  assign add_val   = single ? ACCW'(i) : (ACCW'(i) + ACCW'(quo));
  assign cnt_inc   = single ? aliq_pkg::COUNT_W'(1) : aliq_pkg::COUNT_W'(2);
  assign back_to_n = acc == ACCW'(n);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= aliq_pkg::LIMIT_RESET;
      done  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      done <= (act == aliq_pkg::ACT_FIN_ZERO) || (act == aliq_pkg::ACT_FIN_ONE) ||
              (act == aliq_pkg::ACT_FIN_TWO);
    end
  end

  always_ff @(posedge clk) begin
    unique case (act)
      aliq_pkg::ACT_INIT: begin
        n   <= OPW'(number);
        m   <= OPW'(number);
        i   <= IW'(1);
        sq  <= SQW'(1);
        acc <= '0;
        cnt <= '0;
      end
      aliq_pkg::ACT_ACCUM: begin
        if (divides) begin
          acc <= acc + add_val;
          cnt <= cnt + cnt_inc;
        end
        i  <= i + IW'(1);
        sq <= sq + SQW'({i, 1'b1});
      end
      aliq_pkg::ACT_SAVE1: begin
        s1  <= acc;
        c1  <= cnt;
        m   <= acc[OPW-1:0];
        i   <= IW'(1);
        sq  <= SQW'(1);
        acc <= '0;
        cnt <= '0;
      end
      aliq_pkg::ACT_FIN_ZERO: begin
        divisor_count   <= '0;
        divisor_sum     <= '0;
        is_perfect      <= 1'b0;
        is_amicable_low <= 1'b0;
        partner         <= '0;
      end
      aliq_pkg::ACT_FIN_ONE: begin
        divisor_count   <= c1;
        divisor_sum     <= s1[aliq_pkg::SUM_W-1:0];
        is_perfect      <= s1 == ACCW'(n);
        is_amicable_low <= 1'b0;
        partner         <= '0;
      end
      aliq_pkg::ACT_FIN_TWO: begin
        divisor_count   <= c1;
        divisor_sum     <= s1[aliq_pkg::SUM_W-1:0];
        is_perfect      <= s1 == ACCW'(n);
        is_amicable_low <= back_to_n;
        partner         <= back_to_n ? s1[aliq_pkg::LIMIT_W-1:0] : '0;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/aliq_seq.sv */
// Microcode sequencer: step counter, control program lookup and conditional jumps.
module aliq_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  aliq_pkg::stat_t stat,
  output aliq_pkg::act_t  act,
  output logic            busy
);

  aliq_pkg::step_t  pc;
  aliq_pkg::step_t  pc_next;
  aliq_pkg::uword_t uw;
  logic             take;

  assign uw   = aliq_pkg::ucode(pc);
  assign act  = uw.act;
  assign busy = pc != aliq_pkg::STEP_IDLE;

  always_comb begin
    unique case (uw.br)
      aliq_pkg::BR_NONE:     take = 1'b0;
      aliq_pkg::BR_ALWAYS:   take = 1'b1;
      aliq_pkg::BR_NO_START: take = !start;
      aliq_pkg::BR_LT2:      take = stat.lt2;
      aliq_pkg::BR_SQ_GT_M:  take = stat.sq_gt_m;
      aliq_pkg::BR_DIV_BUSY: take = stat.div_busy;
      aliq_pkg::BR_NOT_CAND: take = !stat.cand;
      default:               take = 1'b1;
    endcase
  end

  always_comb begin
    pc_next = take ? uw.tgt : (pc + aliq_pkg::step_t'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= aliq_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* sim/aliquot_sum_perfect_amicable_unit_tb.sv */
// Self-checking testbench for the aliquot sum, perfect and amicable test unit.
module aliquot_sum_perfect_amicable_unit_tb;

  localparam int NUM_W = aliq_pkg::NUM_BITS_DEFAULT;
  localparam int COUNT_W = aliq_pkg::COUNT_W;
  localparam int SUM_W = aliq_pkg::SUM_W;
  localparam int LIMIT_W = aliq_pkg::LIMIT_W;
  localparam int unsigned CYCLE_LIMIT = 25_000_000;
  localparam int RANDOM_PHASES = 7;
  localparam int RANDOM_PER_PHASE = 9;

  // Perfect numbers and both members of several amicable pairs.
  localparam int unsigned SPECIAL_N = 24;
  localparam int unsigned SPECIAL [SPECIAL_N] = '{
    6, 28, 496, 8128, 220, 284, 1184, 1210, 2620, 2924, 5020, 5564,
    6232, 6368, 10744, 10856, 12285, 14595, 17296, 18416, 63020, 76084,
    66928, 66992
  };

  localparam int unsigned DIRECTED_N = 22;
  localparam int unsigned DIRECTED [DIRECTED_N] = '{
    0, 1, 2, 3, 4, 6, 9, 12, 28, 220, 284, 496, 1184, 1210, 2620, 8128,
    10744, 524288, 720720, 1046529, 1048573, 1048575
  };

  typedef struct packed {
    logic [COUNT_W-1:0] divisor_count;
    logic [SUM_W-1:0]   divisor_sum;
    logic               is_perfect;
    logic               is_amicable_low;
    logic [LIMIT_W-1:0] partner;
  } aliq_report_t;

  typedef struct {
    logic [NUM_W-1:0] number;
    aliq_report_t     report;
  } pending_report_t;

  class aliquot_scoreboard;
    pending_report_t    pending_reports[$];
    logic [LIMIT_W-1:0] partner_limit;
    int unsigned        mismatches;
    int unsigned        reports_checked;
    int unsigned        perfect_seen;
    int unsigned        amicable_seen;

    function new();
      partner_limit = aliq_pkg::LIMIT_RESET;
      mismatches = 0;
      reports_checked = 0;
      perfect_seen = 0;
      amicable_seen = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      partner_limit = value;
    endfunction

    // Proper divisors by trial division; 1 and an exact root count once.
    static function void divisor_stats(input longint unsigned n,
                                       output longint unsigned cnt,
                                       output longint unsigned total);
      longint unsigned i;
      cnt = 0;
      total = 0;
      if (n >= 2) begin
        for (i = 1; i * i <= n; i++) begin
          if (n % i == 0) begin
            if (i == 1 || i * i == n) begin
              cnt += 1;
              total += i;
            end else begin
              cnt += 2;
              total += i + n / i;
            end
          end
        end
      end
    endfunction

    function void note_number(logic [NUM_W-1:0] number);
      pending_report_t entry;
      longint unsigned n, c1, s1, c2, s2;
      logic perfect, amicable;
      n = number;
      divisor_stats(n, c1, s1);
      perfect = (n >= 2) && (s1 == n);
      amicable = 1'b0;
      // The partner's own sum only matters when the partner lies in range.
      if (n >= 2 && !perfect && n < s1 && s1 <= partner_limit) begin
        divisor_stats(s1, c2, s2);
        amicable = (s2 == n);
      end
      entry.number = number;
      entry.report.divisor_count = c1[COUNT_W-1:0];
      entry.report.divisor_sum = s1[SUM_W-1:0];
      entry.report.is_perfect = perfect;
      entry.report.is_amicable_low = amicable;
      entry.report.partner = amicable ? s1[LIMIT_W-1:0] : '0;
      pending_reports.push_back(entry);
    endfunction

    function void check_report(aliq_report_t got);
      pending_report_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: count %0d sum %0d perfect %0b amicable %0b partner %0d",
                   got.divisor_count, got.divisor_sum, got.is_perfect,
                   got.is_amicable_low, got.partner);
        return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      if (got.divisor_count !== want.report.divisor_count ||
          got.divisor_sum !== want.report.divisor_sum ||
          got.is_perfect !== want.report.is_perfect ||
          got.is_amicable_low !== want.report.is_amicable_low ||
          got.partner !== want.report.partner) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("number %0d: expected count %0d sum %0d perfect %0b amicable %0b partner %0d",
                   want.number, want.report.divisor_count, want.report.divisor_sum,
                   want.report.is_perfect, want.report.is_amicable_low,
                   want.report.partner);
          $display("number %0d:      got count %0d sum %0d perfect %0b amicable %0b partner %0d",
                   want.number, got.divisor_count, got.divisor_sum, got.is_perfect,
                   got.is_amicable_low, got.partner);
        end
      end else begin
        if (got.is_perfect) perfect_seen++;
        if (got.is_amicable_low) amicable_seen++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [NUM_W-1:0]   number;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  logic               done;
  logic [COUNT_W-1:0] divisor_count;
  logic [SUM_W-1:0]   divisor_sum;
  logic               is_perfect;
  logic               is_amicable_low;
  logic [LIMIT_W-1:0] partner;

  aliquot_scoreboard sb;
  int unsigned       cycle_count = 0;
  int unsigned       numbers_sent = 0;
  int unsigned       limit_settings = 1;

  aliquot_sum_perfect_amicable_unit #(
    .NUM_BITS(NUM_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .number(number),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .divisor_count(divisor_count),
    .divisor_sum(divisor_sum),
    .is_perfect(is_perfect),
    .is_amicable_low(is_amicable_low),
    .partner(partner)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    aliq_report_t got;
    if (!rst && done) begin
      got.divisor_count = divisor_count;
      got.divisor_sum = divisor_sum;
      got.is_perfect = is_perfect;
      got.is_amicable_low = is_amicable_low;
      got.partner = partner;
      sb.check_report(got);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("aliquot_sum_perfect_amicable_unit regression: fail");
    $finish;
  end

  function automatic int idle_burst();
    return ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 15)) : 0;
  endfunction

  // Mostly cheap numbers; a few reach the full width, where one item is slow.
  function automatic logic [NUM_W-1:0] pick_number();
    int unsigned r, root;
    r = $urandom_range(0, 99);
    if (r < 30) return NUM_W'(SPECIAL[$urandom_range(0, SPECIAL_N - 1)]);
    if (r < 70) return NUM_W'($urandom_range(2, 4095));
    if (r < 88) return NUM_W'($urandom_range(4096, 65535));
    if (r < 95) return NUM_W'($urandom_range(0, 20'hFFFFF));
    if (r < 97) return NUM_W'($urandom_range(0, 1));
    root = $urandom_range(2, 1023);
    return NUM_W'(root * root);
  endfunction

  // Start stays high from one transaction to the next unless a gap is asked for.
  task automatic send_number(input logic [NUM_W-1:0] n, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    number <= n;
    do @(posedge clk); while (busy);
    sb.note_number(n);
    numbers_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_reports.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(value);
    limit_settings++;
  endtask

  initial begin
    logic [LIMIT_W-1:0] limit_value;
    int gap;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    number = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIRECTED_N; k++)
      send_number(NUM_W'(DIRECTED[k]), idle_burst());

    // Each phase probes the pair 220/284 and one above the reset limit.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: limit_value = '0;
        1: limit_value = 20'd1;
        2: limit_value = 20'd2;
        3: limit_value = 20'd283;
        4: limit_value = 20'd284;
        5: limit_value = 20'hFFFFF;
        default: limit_value = LIMIT_W'($urandom_range(2, 20'hFFFFE));
      endcase
      write_limit(limit_value);
      send_number(NUM_W'(220), 0);
      send_number(NUM_W'(10744), 0);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        gap = (p == RANDOM_PHASES - 1) ? 0 : idle_burst();
        send_number(pick_number(), gap);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d numbers under %0d partner limits, %0d results checked",
             numbers_sent, limit_settings, sb.reports_checked);
    $display("correct results flagged %0d perfect and %0d amicable, %0d mismatches",
             sb.perfect_seen, sb.amicable_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("aliquot_sum_perfect_amicable_unit regression: pass");
    end else begin
      $display("aliquot_sum_perfect_amicable_unit regression: fail");
    end
    $finish;
  end

endmodule
